/* hdl/rv32im_instruction_executor_assert.svh */
// Assertion macros for the executor modules.
`ifndef RV32IM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RV32IM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define RVX_AST_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Check that expr holds at every clock edge.
`define RVX_AST_ALWAYS(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);

`endif

/* hdl/rvx_pkg.sv */
// Package with shared constants, codes and types of the RV32IM executor.
package rvx_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int CSR_COUNT     = 4096;
  localparam int CSR_AW        = 12;

  localparam logic [CSR_AW-1:0] CSR_MTVEC    = 12'h305;
  localparam logic [CSR_AW-1:0] CSR_MEPC     = 12'h341;
  localparam logic [CSR_AW-1:0] CSR_MCAUSE   = 12'h342;
  localparam logic [11:0]       IMM_ECALL    = 12'h000;
  localparam logic [11:0]       IMM_MRET     = 12'h302;
  localparam logic [31:0]       MCAUSE_ECALL = 32'd11;
  localparam logic [31:0]       UART_ADDR    = 32'h0000_00F0;
  localparam logic [31:0]       JALR_MASK    = 32'hFFFF_FFFE;
  localparam logic [4:0]        REG_SP       = 5'd2;

  // Item operations.
  localparam logic [1:0] OP_FETCH = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_POKE  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNSUP = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_HALT  = 2'd3;

  // Major opcodes.
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_SUB    = 7'h20;

  // funct3 codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SH   = 3'd1;
  localparam logic [2:0] F3_SW   = 3'd2;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_CSRRW = 3'd1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_RS1, ST_RS2, ST_DEC, ST_EXEC,
    ST_MULWB, ST_DIV, ST_LOAD, ST_LOADWB, ST_STORE, ST_SYS, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CL_SIMPLE, CL_MUL, CL_DIV, CL_LOAD, CL_STORE, CL_ECALL, CL_MRET, CL_CSRRW
  } iclass_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic byte_rd;
    logic fetch_sel;
    logic byte_wr;
    logic rd_a;
    logic rd_b;
    logic cap_b;
    logic exec;
    logic div_start;
    logic mul_wb;
    logic div_wb;
    logic load_wb;
    logic sys_wb;
    logic halt;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       pc_fits;
    logic       halt_word;
    logic       fetch_done;
    logic       load_done;
    logic       wr_done;
    logic       div_done;
    iclass_t    cls;
    logic [1:0] req_op;
  } stat_t;

endpackage

/* hdl/rvx_req_if.sv */
// Request channel: one item per transaction.
interface rvx_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] instr_word;
  logic [11:0] load_address;
  logic [7:0]  load_byte;

  modport source (output valid, output op, output instr_word, output load_address,
                  output load_byte, input ready);
  modport sink (input valid, input op, input instr_word, input load_address,
                input load_byte, output ready);
endinterface

/* hdl/rvx_rsp_if.sv */
// Result channel: one result per transaction.
interface rvx_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic        dest_written;
  logic [31:0] new_pc;
  logic        trap_taken;
  logic        uart_valid;
  logic [7:0]  uart_byte;
  logic [1:0]  status;

  modport source (output valid, output dest_index, output dest_value, output dest_written,
                  output new_pc, output trap_taken, output uart_valid, output uart_byte,
                  output status, input ready);
  modport sink (input valid, input dest_index, input dest_value, input dest_written,
                input new_pc, input trap_taken, input uart_valid, input uart_byte,
                input status, output ready);
endinterface

/* hdl/rvx_ram.sv */
// Generic single-write, single-read RAM with registered read (old data on collision).
module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/rvx_div.sv */
// Iterative signed divider, one quotient bit per cycle.
module rvx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        want_rem,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] result
);
  logic        busy;
  logic [4:0]  step;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic        neg_q;
  logic        neg_r;
  logic        rem_sel;
  logic        special;
  logic [31:0] spec_val;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      special <= (divisor == '0) || (dividend == 32'h8000_0000 && divisor == '1);
      busy    <= !((divisor == '0) || (dividend == 32'h8000_0000 && divisor == '1));
      done    <= (divisor == '0) || (dividend == 32'h8000_0000 && divisor == '1);
    end else if (busy && step == 5'd31) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= dividend[31] ? (32'd0 - dividend) : dividend;
      dsr      <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem      <= '0;
      step     <= '0;
      neg_q    <= dividend[31] ^ divisor[31];
      neg_r    <= dividend[31];
      rem_sel  <= want_rem;
      if (divisor == '0) begin
        spec_val <= want_rem ? dividend : '1;
      end else begin
        spec_val <= want_rem ? '0 : dividend;
      end
    end else if (busy) begin
      step <= step + 5'd1;
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (special) begin
      result = spec_val;
    end else if (rem_sel) begin
      result = neg_r ? (32'd0 - rem) : rem;
    end else begin
      result = neg_q ? (32'd0 - quo) : quo;
    end
  end
endmodule

/* hdl/rvx_ctrl.sv */
// Sequencer of the executor: state machine, request ready and result valid.
module rvx_ctrl import rvx_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take = 1'b1;
          case (stat.req_op)
            OP_FETCH: state_next = stat.pc_fits ? ST_FETCH : ST_DONE;
            OP_EXEC:  state_next = ST_RS1;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.byte_rd   = 1'b1;
        cmd.fetch_sel = 1'b1;
        if (stat.fetch_done) begin
          state_next = ST_RS1;
        end
      end
      ST_RS1: begin
        if (stat.halt_word) begin
          cmd.halt   = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.rd_a   = 1'b1;
          state_next = ST_RS2;
        end
      end
      ST_RS2: begin
        cmd.rd_b   = 1'b1;
        state_next = ST_DEC;
      end
      ST_DEC: begin
        cmd.cap_b  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.cls)
          CL_MUL:   state_next = ST_MULWB;
          CL_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
          CL_LOAD:  state_next = ST_LOAD;
          CL_STORE: state_next = ST_STORE;
          CL_ECALL, CL_MRET, CL_CSRRW: state_next = ST_SYS;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_MULWB: begin
        cmd.mul_wb = 1'b1;
        state_next = ST_DONE;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.div_wb = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_LOAD: begin
        cmd.byte_rd = 1'b1;
        if (stat.load_done) begin
          state_next = ST_LOADWB;
        end
      end
      ST_LOADWB: begin
        cmd.load_wb = 1'b1;
        state_next  = ST_DONE;
      end
      ST_STORE: begin
        cmd.byte_wr = 1'b1;
        if (stat.wr_done) begin
          state_next = ST_DONE;
        end
      end
      ST_SYS: begin
        cmd.sys_wb = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

`include "rv32im_instruction_executor_assert.svh"

  `RVX_AST_IMP(a_out_free, clk, rst, cmd.out_load, !rsp_valid || rsp_ready, "result overwritten")
  `RVX_AST_IMP(a_rsp_src, clk, rst, $rose(rsp_valid), $past(cmd.out_load), "stray result valid")
  `RVX_AST_ALWAYS(a_wb_one, clk, rst, $onehot0({cmd.exec, cmd.mul_wb, cmd.div_wb, cmd.load_wb, cmd.sys_wb}), "two writebacks at once")
endmodule

/* hdl/rvx_dpath.sv */
// Datapath: architectural state, memories, ALU, multiplier and result registers.
module rvx_dpath import rvx_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  op,
  input  logic [31:0] instr_word,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_byte,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic        dest_written,
  output logic [31:0] new_pc,
  output logic        trap_taken,
  output logic        uart_valid,
  output logic [7:0]  uart_byte,
  output logic [1:0]  status
);
  localparam int MAW   = $clog2(MEM_BYTES);
  localparam int CLR_N = (MEM_BYTES > CSR_COUNT) ? MEM_BYTES : CSR_COUNT;
  localparam int CLW   = $clog2(CLR_N);
  localparam logic [31:0] MEM_TOP = 32'(MEM_BYTES);

  logic [31:0] pc;
  logic [31:0] instr;
  logic [1:0]  op_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [31:0] ea_q;
  logic [31:0] ldata;
  logic [63:0] prod;
  logic [2:0]  cnt;
  logic [CLW-1:0] clr_ptr;
  logic [31:0] rf_valid;
  logic        rv_q;
  logic        sp_q;
  logic [4:0]  r_idx;
  logic [31:0] r_val;
  logic        r_wr;
  logic        r_trap;
  logic        r_uv;
  logic [7:0]  r_ub;
  logic [1:0]  r_stat;

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [11:0] csel;
  logic [31:0] ofs_i, ofs_s, ofs_b, ofs_j, ofs_u;
  logic [2:0]  n_acc;
  logic        fits;
  logic        uart_hit;
  iclass_t     cls;

  logic        ex_wr;
  logic [31:0] ex_val;
  logic [31:0] ex_pc;
  logic [1:0]  ex_stat;
  logic        ex_uv;
  logic [7:0]  ex_ub;

  logic        wb_en;
  logic [31:0] wb_val;
  logic [31:0] ld_ext;

  logic [4:0]  rf_raddr;
  logic [31:0] rf_rdata;
  logic [31:0] rf_rd;

  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;
  logic [MAW-1:0] mem_raddr;
  logic [7:0]     mem_rdata;

  logic              csr_we;
  logic [CSR_AW-1:0] csr_waddr;
  logic [31:0]       csr_wdata;
  logic [CSR_AW-1:0] csr_raddr;
  logic [31:0]       csr_rdata;

  logic        div_done;
  logic [31:0] div_res;
  logic [1:0]  bsel;

  assign opc  = instr[6:0];
  assign rd   = instr[11:7];
  assign f3   = instr[14:12];
  assign f7   = instr[31:25];
  assign csel = instr[31:20];

  assign ofs_i = {{20{instr[31]}}, instr[31:20]};
  assign ofs_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign ofs_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign ofs_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign ofs_u = {instr[31:12], 12'h000};

  always_comb begin
    case (f3[1:0])
      2'd0:    n_acc = 3'd1;
      2'd1:    n_acc = 3'd2;
      default: n_acc = 3'd4;
    endcase
  end

  assign fits     = ea_q <= (MEM_TOP - 32'(n_acc));
  assign uart_hit = (ea_q == UART_ADDR) && (f3 != F3_SH);

  // Classify the instruction for the sequencer.
  always_comb begin
    cls = CL_SIMPLE;
    case (opc)
      OPC_REG: begin
        if (f7 == F7_MULDIV) begin
          if (f3 inside {F3_MUL, F3_MULH}) begin
            cls = CL_MUL;
          end else if (f3 inside {F3_DIV, F3_REM}) begin
            cls = CL_DIV;
          end
        end
      end
      OPC_LOAD: begin
        if ((f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) && fits) begin
          cls = CL_LOAD;
        end
      end
      OPC_STORE: begin
        if ((f3 inside {F3_SB, F3_SH, F3_SW}) && !uart_hit && fits) begin
          cls = CL_STORE;
        end
      end
      OPC_SYSTEM: begin
        if (csel == IMM_ECALL && f3 == F3_PRIV) begin
          cls = CL_ECALL;
        end else if (csel == IMM_MRET && f3 == F3_PRIV) begin
          cls = CL_MRET;
        end else if (f3 == F3_CSRRW) begin
          cls = CL_CSRRW;
        end
      end
      default: cls = CL_SIMPLE;
    endcase
  end

  // Combinational execute: ALU, branches, jumps and the error cases.
  always_comb begin
    ex_wr   = 1'b0;
    ex_val  = '0;
    ex_pc   = pc + 32'd4;
    ex_stat = STAT_OK;
    ex_uv   = 1'b0;
    ex_ub   = '0;
    case (opc)
      OPC_SYSTEM: begin
        if (!(cls inside {CL_ECALL, CL_MRET, CL_CSRRW})) begin
          ex_stat = STAT_UNSUP;
        end
      end
      OPC_IMM: begin
        ex_wr = 1'b1;
        case (f3)
          F3_ADD:  ex_val = a_q + ofs_i;
          F3_SLL:  ex_val = a_q << instr[24:20];
          F3_SLT:  ex_val = {31'd0, $signed(a_q) < $signed(ofs_i)};
          F3_SLTU: ex_val = {31'd0, a_q < ofs_i};
          F3_SR:   ex_val = instr[30] ? 32'($signed(a_q) >>> instr[24:20])
                                      : a_q >> instr[24:20];
          default: begin
            ex_wr   = 1'b0;
            ex_stat = STAT_UNSUP;
          end
        endcase
      end
      OPC_REG: begin
        if (f7 == F7_MULDIV) begin
          if (!(f3 inside {F3_MUL, F3_MULH, F3_DIV, F3_REM})) begin
            ex_stat = STAT_UNSUP;
          end
        end else begin
          ex_wr = 1'b1;
          case (f3)
            F3_ADD: begin
              if (f7 == F7_BASE) begin
                ex_val = a_q + b_q;
              end else if (f7 == F7_SUB) begin
                ex_val = a_q - b_q;
              end else begin
                ex_wr   = 1'b0;
                ex_stat = STAT_UNSUP;
              end
            end
            F3_SLL:  ex_val = a_q << b_q[4:0];
            F3_SLT:  ex_val = {31'd0, $signed(a_q) < $signed(b_q)};
            F3_SLTU: ex_val = {31'd0, a_q < b_q};
            F3_XOR:  ex_val = a_q ^ b_q;
            F3_SR:   ex_val = instr[30] ? 32'($signed(a_q) >>> b_q[4:0]) : a_q >> b_q[4:0];
            F3_OR:   ex_val = a_q | b_q;
            default: ex_val = a_q & b_q;
          endcase
        end
      end
      OPC_LOAD: begin
        if (!(f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU})) begin
          ex_wr   = 1'b1;
          ex_stat = STAT_UNSUP;
        end else if (!fits) begin
          ex_wr   = 1'b1;
          ex_stat = STAT_RANGE;
        end
      end
      OPC_STORE: begin
        if (!(f3 inside {F3_SB, F3_SH, F3_SW})) begin
          ex_stat = STAT_UNSUP;
        end else if (uart_hit) begin
          ex_uv = 1'b1;
          ex_ub = b_q[7:0];
        end else if (!fits) begin
          ex_stat = STAT_RANGE;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  if (a_q == b_q) ex_pc = pc + ofs_b;
          F3_BNE:  if (a_q != b_q) ex_pc = pc + ofs_b;
          F3_BLT:  if ($signed(a_q) < $signed(b_q)) ex_pc = pc + ofs_b;
          F3_BGE:  if (!($signed(a_q) < $signed(b_q))) ex_pc = pc + ofs_b;
          default: ex_stat = STAT_UNSUP;
        endcase
      end
      OPC_JAL: begin
        ex_wr  = 1'b1;
        ex_val = pc + 32'd4;
        ex_pc  = pc + ofs_j;
      end
      OPC_JALR: begin
        ex_wr  = 1'b1;
        ex_val = pc + 32'd4;
        ex_pc  = (a_q + ofs_i) & JALR_MASK;
      end
      OPC_LUI: begin
        ex_wr  = 1'b1;
        ex_val = ofs_u;
      end
      OPC_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc + ofs_u;
      end
      default: ex_stat = STAT_UNSUP;
    endcase
  end

  always_comb begin
    case (f3)
      F3_LB:   ld_ext = {{24{ldata[7]}}, ldata[7:0]};
      F3_LH:   ld_ext = {{16{ldata[15]}}, ldata[15:0]};
      F3_LW:   ld_ext = ldata;
      F3_LBU:  ld_ext = {24'd0, ldata[7:0]};
      F3_LHU:  ld_ext = {16'd0, ldata[15:0]};
      default: ld_ext = '0;
    endcase
  end

  // Register writeback select.
  always_comb begin
    wb_en  = 1'b0;
    wb_val = ex_val;
    if (cmd.exec) begin
      wb_en = ex_wr;
    end else if (cmd.mul_wb) begin
      wb_en  = 1'b1;
      wb_val = (f3 == F3_MULH) ? prod[63:32] : prod[31:0];
    end else if (cmd.div_wb) begin
      wb_en  = 1'b1;
      wb_val = div_res;
    end else if (cmd.load_wb) begin
      wb_en  = 1'b1;
      wb_val = ld_ext;
    end else if (cmd.sys_wb) begin
      wb_en  = (cls == CL_CSRRW);
      wb_val = csr_rdata;
    end
  end

  // Register file: x0 is never written, so its valid bit stays clear and it reads zero.
  assign rf_raddr = cmd.rd_b ? instr[24:20] : instr[19:15];
  assign rf_rd    = rv_q ? rf_rdata : (sp_q ? MEM_TOP : '0);

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
    .clk   (clk),
    .we    (wb_en && rd != 5'd0),
    .waddr (rd),
    .wdata (wb_val),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  always_ff @(posedge clk) begin
    rv_q <= rf_valid[rf_raddr];
    sp_q <= (rf_raddr == REG_SP);
  end

  // Byte memory ports.
  assign bsel = cnt[1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = MAW'(ea_q + 32'(cnt));
    mem_wdata = b_q[{bsel, 3'b000} +: 8];
    if (cmd.clear) begin
      mem_we    = 32'(clr_ptr) < MEM_TOP;
      mem_waddr = MAW'(clr_ptr);
      mem_wdata = '0;
    end else if (cmd.take) begin
      mem_we    = (op == OP_POKE) && (32'(load_address) < MEM_TOP);
      mem_waddr = MAW'(load_address);
      mem_wdata = load_byte;
    end else if (cmd.byte_wr) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = cmd.fetch_sel ? MAW'(pc + 32'(cnt)) : MAW'(ea_q + 32'(cnt));

  rvx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // CSR file ports.
  always_comb begin
    csr_we    = 1'b0;
    csr_waddr = csel;
    csr_wdata = a_q;
    if (cmd.clear) begin
      csr_we    = 32'(clr_ptr) < 32'(CSR_COUNT);
      csr_waddr = CSR_AW'(clr_ptr);
      csr_wdata = '0;
    end else if (cmd.exec && cls == CL_ECALL) begin
      csr_we    = 1'b1;
      csr_waddr = CSR_MEPC;
      csr_wdata = pc + 32'd4;
    end else if (cmd.exec && cls == CL_CSRRW) begin
      csr_we = 1'b1;
    end else if (cmd.sys_wb && cls == CL_ECALL) begin
      csr_we    = 1'b1;
      csr_waddr = CSR_MCAUSE;
      csr_wdata = MCAUSE_ECALL;
    end
  end

  always_comb begin
    case (cls)
      CL_ECALL: csr_raddr = CSR_MTVEC;
      CL_MRET:  csr_raddr = CSR_MEPC;
      default:  csr_raddr = csel;
    endcase
  end

  rvx_ram #(.WIDTH(32), .DEPTH(CSR_COUNT)) u_csr (
    .clk   (clk),
    .we    (csr_we),
    .waddr (csr_waddr),
    .wdata (csr_wdata),
    .raddr (csr_raddr),
    .rdata (csr_rdata)
  );

  rvx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .want_rem (f3 == F3_REM),
    .dividend (a_q),
    .divisor  (b_q),
    .done     (div_done),
    .result   (div_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      clr_ptr  <= '0;
      rf_valid <= '0;
      cnt      <= '0;
    end else begin
      cnt <= (cmd.byte_rd || cmd.byte_wr) ? cnt + 3'd1 : 3'd0;
      if (cmd.clear && clr_ptr != CLW'(CLR_N - 1)) begin
        clr_ptr <= clr_ptr + CLW'(1);
      end
      if (wb_en && rd != 5'd0) begin
        rf_valid[rd] <= 1'b1;
      end
      if (cmd.exec) begin
        pc <= ex_pc;
      end else if (cmd.sys_wb && (cls inside {CL_ECALL, CL_MRET})) begin
        pc <= csr_rdata;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      instr  <= instr_word;
      op_q   <= op;
      r_idx  <= '0;
      r_val  <= '0;
      r_wr   <= 1'b0;
      r_trap <= 1'b0;
      r_uv   <= 1'b0;
      r_ub   <= '0;
      if (op == OP_NONE) begin
        r_stat <= STAT_UNSUP;
      end else if (op == OP_FETCH && !stat.pc_fits) begin
        r_stat <= STAT_HALT;
      end else begin
        r_stat <= STAT_OK;
      end
    end
    if (cmd.byte_rd && cnt != 3'd0) begin
      if (cmd.fetch_sel) begin
        instr[{bsel - 2'd1, 3'b000} +: 8] <= mem_rdata;
      end else begin
        ldata[{bsel - 2'd1, 3'b000} +: 8] <= mem_rdata;
      end
    end
    if (cmd.halt) begin
      r_stat <= STAT_HALT;
    end
    if (cmd.rd_b) begin
      a_q <= rf_rd;
    end
    if (cmd.cap_b) begin
      b_q  <= rf_rd;
      ea_q <= a_q + ((opc == OPC_STORE) ? ofs_s : ofs_i);
    end
    if (cmd.exec) begin
      prod   <= 64'($signed(a_q) * $signed(b_q));
      r_stat <= ex_stat;
      r_uv   <= ex_uv;
      r_ub   <= ex_ub;
    end
    if (cmd.sys_wb && cls == CL_ECALL) begin
      r_trap <= 1'b1;
    end
    if (wb_en && rd != 5'd0) begin
      r_idx <= rd;
      r_val <= wb_val;
      r_wr  <= 1'b1;
    end
    if (cmd.out_load) begin
      dest_index   <= r_idx;
      dest_value   <= r_val;
      dest_written <= r_wr;
      new_pc       <= pc;
      trap_taken   <= r_trap;
      uart_valid   <= r_uv;
      uart_byte    <= r_ub;
      status       <= r_stat;
    end
  end

  // Status to the sequencer.
  always_comb begin
    stat.clear_done = (clr_ptr == CLW'(CLR_N - 1));
    stat.pc_fits    = pc <= (MEM_TOP - 32'd4);
    stat.halt_word  = (instr == '0) && (op_q == OP_FETCH);
    stat.fetch_done = (cnt == 3'd4);
    stat.load_done  = (cnt == n_acc);
    stat.wr_done    = (cnt == n_acc - 3'd1);
    stat.div_done   = div_done;
    stat.cls        = cls;
    stat.req_op     = op;
  end
endmodule

/* hdl/rv32im_instruction_executor.sv */
// Top level of the RV32IM executor: sequencer, datapath and channel wiring.
//
// Channels: req carries one item per transaction (op, instr_word, load_address,
// load_byte); rsp returns exactly one result per item, in order. Both use
// valid/ready; a transaction happens on a clock edge with both high.
// After reset the block sweeps data memory and the CSR file to zero, one entry
// per cycle over max(MEM_BYTES, 4096) entries; req.ready stays low meanwhile.
// A memory byte write or an unused op goes straight to the output register; an
// executed word (op 1) reads rs1 and rs2, decodes and executes, plus a
// writeback step for MUL/MULH and ECALL/MRET/CSRRW, n byte reads and a
// writeback for an n-byte load, n byte writes for an n-byte store, and the
// shared divider for DIV/REM (one quotient bit per cycle; skipped when the
// divisor is zero or the quotient overflows). A fetch (op 0) first does four
// byte reads. Byte memory and register file each have one read port; register
// operands come one per cycle. One item is worked on at a time; the next one is
// accepted the cycle after a result moves into the output register, so a
// stalled receiver holds only the finished result while the next item runs.
// Registers start at zero except x2, which holds MEM_BYTES; pc starts at zero.
module rv32im_instruction_executor import rvx_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input logic      clk,
  input logic      rst,
  rvx_req_if.sink  req,
  rvx_rsp_if.source rsp
);
  cmd_t  cmd;
  stat_t stat;

  // Sequencer: owns the handshakes and steps the datapath.
  rvx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: state, memories and the output register.
  rvx_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (req.op),
    .instr_word   (req.instr_word),
    .load_address (req.load_address),
    .load_byte    (req.load_byte),
    .dest_index   (rsp.dest_index),
    .dest_value   (rsp.dest_value),
    .dest_written (rsp.dest_written),
    .new_pc       (rsp.new_pc),
    .trap_taken   (rsp.trap_taken),
    .uart_valid   (rsp.uart_valid),
    .uart_byte    (rsp.uart_byte),
    .status       (rsp.status)
  );
endmodule

/* verif/tb_rv32im_instruction_executor.sv */
// Self-checking testbench for the RV32IM instruction executor.
module tb_rv32im_instruction_executor;
  import rvx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM = MEM_BYTES_DEF;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
    logic [11:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic [31:0] new_pc;
    logic        trap_taken;
    logic        uart_valid;
    logic [7:0]  uart_byte;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    item_t it;
    logic  typed;
    res_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rvx_req_if req ();
  rvx_rsp_if rsp ();

  rv32im_instruction_executor DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow architectural state of the core.
  logic [31:0] shadow_pc;
  logic [31:0] shadow_regs [32];
  logic [7:0]  shadow_mem [MEM];
  logic [31:0] shadow_csr [CSR_COUNT];

  res_t pending_results [$];
  int   errors = 0;
  bit   calm = 1'b0;   // no idling or stalls in the final stretch
  int   stall_left = 0;

  // ---------------------------------------------------------------------------
  // Instruction encoders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit in_mem(logic [31:0] ea, int n);
    return ({1'b0, ea} + 33'(n)) <= 33'(MEM);
  endfunction

  function automatic logic [31:0] read_le(logic [31:0] ea, int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v |= 32'(shadow_mem[ea + k]) << (8 * k);
    return v;
  endfunction

  function automatic void set_dest(logic [4:0] d, logic [31:0] v, inout res_t r);
    if (d != 5'd0) begin
      shadow_regs[d] = v;
      r.dest_index = d;
      r.dest_value = v;
      r.dest_written = 1'b1;
    end
  endfunction

  function automatic logic [31:0] mul_high(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return p[63:32];
  endfunction

  function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b, bit want_rem);
    if (b == '0) return want_rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return want_rem ? 32'd0 : a;
    return want_rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
  endfunction

  function automatic void execute_word(logic [31:0] w, inout res_t r);
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, here, after, imm_i, imm_s, imm_b, imm_j, ea, v;
    logic [11:0] csel;
    int n;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = shadow_regs[w[19:15]];
    b = shadow_regs[w[24:20]];
    here = shadow_pc;
    after = here + 32'd4;
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    csel = w[31:20];
    case (opc)
      OPC_SYSTEM: begin
        if (csel == IMM_ECALL && f3 == F3_PRIV) begin
          shadow_csr[CSR_MEPC] = here + 32'd4;
          shadow_csr[CSR_MCAUSE] = MCAUSE_ECALL;
          after = shadow_csr[CSR_MTVEC];
          r.trap_taken = 1'b1;
        end else if (csel == IMM_MRET && f3 == F3_PRIV) begin
          after = shadow_csr[CSR_MEPC];
        end else if (f3 == F3_CSRRW) begin
          v = shadow_csr[csel];
          shadow_csr[csel] = a;
          set_dest(rd, v, r);
        end else begin
          r.status = STAT_UNSUP;
        end
      end
      OPC_IMM: begin
        case (f3)
          F3_ADD:  set_dest(rd, a + imm_i, r);
          F3_SLL:  set_dest(rd, a << imm_i[4:0], r);
          F3_SLT:  set_dest(rd, 32'($signed(a) < $signed(imm_i)), r);
          F3_SLTU: set_dest(rd, 32'(a < imm_i), r);
          F3_SR:   set_dest(rd, w[30] ? 32'($signed(a) >>> imm_i[4:0]) : a >> imm_i[4:0], r);
          default: r.status = STAT_UNSUP;
        endcase
      end
      OPC_REG: begin
        if (f7 == F7_MULDIV) begin
          case (f3)
            F3_MUL:  set_dest(rd, a * b, r);
            F3_MULH: set_dest(rd, mul_high(a, b), r);
            F3_DIV:  set_dest(rd, signed_divide(a, b, 1'b0), r);
            F3_REM:  set_dest(rd, signed_divide(a, b, 1'b1), r);
            default: r.status = STAT_UNSUP;
          endcase
        end else begin
          case (f3)
            F3_ADD: begin
              if (f7 == F7_BASE) set_dest(rd, a + b, r);
              else if (f7 == F7_SUB) set_dest(rd, a - b, r);
              else r.status = STAT_UNSUP;
            end
            F3_SLL:  set_dest(rd, a << b[4:0], r);
            F3_SLT:  set_dest(rd, 32'($signed(a) < $signed(b)), r);
            F3_SLTU: set_dest(rd, 32'(a < b), r);
            F3_XOR:  set_dest(rd, a ^ b, r);
            F3_SR:   set_dest(rd, w[30] ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0], r);
            F3_OR:   set_dest(rd, a | b, r);
            default: set_dest(rd, a & b, r);
          endcase
        end
      end
      OPC_LOAD: begin
        ea = a + imm_i;
        n = (f3[1:0] == 2'd0) ? 1 : (f3[1:0] == 2'd1) ? 2 : 4;
        if (f3 == 3'd3 || f3 > F3_LHU) begin
          r.status = STAT_UNSUP;
          set_dest(rd, '0, r);
        end else if (!in_mem(ea, n)) begin
          r.status = STAT_RANGE;
          set_dest(rd, '0, r);
        end else begin
          v = read_le(ea, n);
          if (f3 == F3_LB) v = {{24{v[7]}}, v[7:0]};
          else if (f3 == F3_LH) v = {{16{v[15]}}, v[15:0]};
          set_dest(rd, v, r);
        end
      end
      OPC_STORE: begin
        ea = a + imm_s;
        if (f3 > F3_SW) begin
          r.status = STAT_UNSUP;
        end else if (ea == UART_ADDR && f3 != F3_SH) begin
          r.uart_valid = 1'b1;
          r.uart_byte = b[7:0];
        end else begin
          n = (f3 == F3_SB) ? 1 : (f3 == F3_SH) ? 2 : 4;
          if (in_mem(ea, n)) begin
            for (int k = 0; k < n; k++) shadow_mem[ea + k] = b[8 * k +: 8];
          end else begin
            r.status = STAT_RANGE;
          end
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  if (a == b) after = here + imm_b;
          F3_BNE:  if (a != b) after = here + imm_b;
          F3_BLT:  if ($signed(a) < $signed(b)) after = here + imm_b;
          F3_BGE:  if (!($signed(a) < $signed(b))) after = here + imm_b;
          default: r.status = STAT_UNSUP;
        endcase
      end
      OPC_JAL: begin
        set_dest(rd, here + 32'd4, r);
        after = here + imm_j;
      end
      OPC_JALR: begin
        after = (a + imm_i) & JALR_MASK;
        set_dest(rd, here + 32'd4, r);
      end
      OPC_LUI:   set_dest(rd, {w[31:12], 12'd0}, r);
      OPC_AUIPC: set_dest(rd, here + {w[31:12], 12'd0}, r);
      default:   r.status = STAT_UNSUP;
    endcase
    shadow_regs[0] = '0;
    shadow_pc = after;
  endfunction

  function automatic res_t predict_result(item_t it);
    res_t r;
    r = '0;
    case (it.op)
      OP_FETCH: begin
        if (!in_mem(shadow_pc, 4) || read_le(shadow_pc, 4) == '0) r.status = STAT_HALT;
        else execute_word(read_le(shadow_pc, 4), r);
      end
      OP_EXEC: execute_word(it.word, r);
      OP_POKE: shadow_mem[it.addr] = it.data;
      default: r.status = STAT_UNSUP;
    endcase
    r.new_pc = shadow_pc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random instruction source: mostly legal encodings with random fields
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] pick_reg();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] random_word();
    logic [6:0] f7;
    logic [11:0] csr_sel;
    case ($urandom_range(0, 13))
      0, 1: begin
        case ($urandom_range(0, 3))
          0: f7 = F7_BASE;
          1: f7 = F7_SUB;
          2: f7 = F7_MULDIV;
          default: f7 = 7'($urandom);
        endcase
        return enc_r(f7, pick_reg(), pick_reg(), 3'($urandom), pick_reg(), OPC_REG);
      end
      2: return enc_r(F7_MULDIV, pick_reg(), pick_reg(), 3'($urandom), pick_reg(), OPC_REG);
      3, 4: return enc_i(12'($urandom), pick_reg(), 3'($urandom), pick_reg(), OPC_IMM);
      5: return {20'($urandom), pick_reg(), OPC_LUI};
      // loads and stores: half use x0 as base so most addresses land in memory
      6: return enc_i($urandom_range(0, 1) ? 12'($urandom_range(0, 2047)) : 12'($urandom),
                      $urandom_range(0, 1) ? 5'd0 : pick_reg(), 3'($urandom), pick_reg(),
                      OPC_LOAD);
      7: begin
        if ($urandom_range(0, 3) == 0)
          return enc_s(12'(UART_ADDR), pick_reg(), 5'd0, 3'($urandom_range(0, 2)));
        return enc_s($urandom_range(0, 1) ? 12'($urandom_range(0, 2047)) : 12'($urandom),
                     pick_reg(), $urandom_range(0, 1) ? 5'd0 : pick_reg(),
                     3'($urandom_range(0, 3)));
      end
      8: return enc_b(13'($urandom), pick_reg(), pick_reg(), 3'($urandom));
      9: return $urandom_range(0, 1) ? enc_j(21'($urandom), pick_reg())
                                     : enc_i(12'($urandom), pick_reg(), 3'($urandom),
                                             pick_reg(), OPC_JALR);
      10: return {20'($urandom), pick_reg(), OPC_AUIPC};
      11: begin
        case ($urandom_range(0, 4))
          0: csr_sel = CSR_MTVEC;
          1: csr_sel = CSR_MEPC;
          2: csr_sel = CSR_MCAUSE;
          default: csr_sel = 12'($urandom);
        endcase
        return enc_i(csr_sel, pick_reg(), $urandom_range(0, 3) == 0 ? 3'($urandom) : F3_CSRRW,
                     pick_reg(), OPC_SYSTEM);
      end
      12: return $urandom_range(0, 1) ? enc_i(IMM_ECALL, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM)
                                      : enc_i(IMM_MRET, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: change inputs at the falling edge, look for accept at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it, logic typed, res_t want);
    res_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    @(negedge clk);
    req.op = it.op;
    req.instr_word = it.word;
    req.load_address = it.addr;
    req.load_byte = it.data;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    // Advance the shadow state on every transaction; typed rows override the prediction.
    r = predict_result(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] word, logic [11:0] addr,
                         logic [7:0] data);
    item_t it;
    it = '{op: op, word: word, addr: addr, data: data};
    send_item(it, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, then compare at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp.ready = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      rsp.ready = 1'b0;
    end else begin
      rsp.ready = 1'b1;
    end
  end

  task automatic flag_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $realtime, name, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual pc 0x%0h",
                 $realtime, rsp.new_pc);
        errors++;
      end else begin
        w = pending_results.pop_front();
        if (rsp.dest_index !== w.dest_index)
          flag_field("dest_index", w.dest_index, rsp.dest_index);
        if (rsp.dest_value !== w.dest_value)
          flag_field("dest_value", w.dest_value, rsp.dest_value);
        if (rsp.dest_written !== w.dest_written)
          flag_field("dest_written", w.dest_written, rsp.dest_written);
        if (rsp.new_pc !== w.new_pc) flag_field("new_pc", w.new_pc, rsp.new_pc);
        if (rsp.trap_taken !== w.trap_taken)
          flag_field("trap_taken", w.trap_taken, rsp.trap_taken);
        if (rsp.uart_valid !== w.uart_valid)
          flag_field("uart_valid", w.uart_valid, rsp.uart_valid);
        if (rsp.uart_byte !== w.uart_byte) flag_field("uart_byte", w.uart_byte, rsp.uart_byte);
        if (rsp.status !== w.status) flag_field("status", w.status, rsp.status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, then random traffic
  // ---------------------------------------------------------------------------
  function automatic row_t mk(logic [1:0] op, logic [31:0] word, logic [11:0] addr,
                              logic [7:0] data);
    row_t row;
    row = '0;
    row.it = '{op: op, word: word, addr: addr, data: data};
    return row;
  endfunction

  function automatic row_t mkx(row_t row, logic [4:0] idx, logic [31:0] val, logic wr,
                               logic [31:0] pc, logic trap, logic uv, logic [7:0] ub,
                               logic [1:0] st);
    row.typed = 1'b1;
    row.want = '{dest_index: idx, dest_value: val, dest_written: wr, new_pc: pc,
                 trap_taken: trap, uart_valid: uv, uart_byte: ub, status: st};
    return row;
  endfunction

  initial begin
    row_t rows [$];
    logic [31:0] prog;
    int sent;
    req.valid = 1'b0;
    req.op = OP_FETCH;
    req.instr_word = '0;
    req.load_address = '0;
    req.load_byte = '0;
    rsp.ready = 1'b0;

    shadow_pc = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_regs[REG_SP] = 32'(MEM);
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    foreach (shadow_csr[i]) shadow_csr[i] = '0;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    prog = enc_i(12'd5, 5'd0, F3_ADD, 5'd14, OPC_IMM);
    // Empty memory halts the fetch; the unused op only reports unsupported.
    rows.push_back(mkx(mk(OP_FETCH, '0, '0, '0), 0, 0, 0, 0, 0, 0, 0, STAT_HALT));
    rows.push_back(mkx(mk(OP_NONE, '1, '1, '1), 0, 0, 0, 0, 0, 0, 0, STAT_UNSUP));
    rows.push_back(mkx(mk(OP_POKE, '0, 12'hFFF, 8'hFF), 0, 0, 0, 0, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_POKE, '0, 12'h000, 8'h00), 0, 0, 0, 0, 0, 0, 0, STAT_OK));
    // Build the most negative value and -1, then hit the division corner cases.
    rows.push_back(mkx(mk(OP_EXEC, {20'h80000, 5'd1, OPC_LUI}, '0, '0),
                       1, 32'h8000_0000, 1, 4, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_i(12'hFFF, 5'd0, F3_ADD, 5'd3, OPC_IMM), '0, '0),
                       3, 32'hFFFF_FFFF, 1, 8, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_r(F7_MULDIV, 5'd3, 5'd1, F3_DIV, 5'd4, OPC_REG), '0,
                          '0), 4, 32'h8000_0000, 1, 12, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_r(F7_MULDIV, 5'd3, 5'd1, F3_REM, 5'd5, OPC_REG), '0,
                          '0), 5, 32'h0, 1, 16, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd6, OPC_REG), '0,
                          '0), 6, 32'hFFFF_FFFF, 1, 20, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_r(F7_MULDIV, 5'd0, 5'd1, F3_REM, 5'd7, OPC_REG), '0,
                          '0), 7, 32'h8000_0000, 1, 24, 0, 0, 0, STAT_OK));
    rows.push_back(mk(OP_EXEC, enc_r(F7_MULDIV, 5'd1, 5'd1, F3_MULH, 5'd8, OPC_REG), '0, '0));
    rows.push_back(mk(OP_EXEC, enc_r(F7_MULDIV, 5'd3, 5'd3, F3_MUL, 5'd9, OPC_REG), '0, '0));
    // Byte store to the UART port emits, a halfword there writes memory instead.
    rows.push_back(mkx(mk(OP_EXEC, enc_s(12'(UART_ADDR), 5'd3, 5'd0, F3_SB), '0, '0),
                       0, 0, 0, 36, 0, 1, 8'hFF, STAT_OK));
    rows.push_back(mk(OP_EXEC, enc_s(12'(UART_ADDR), 5'd3, 5'd0, F3_SH), '0, '0));
    rows.push_back(mk(OP_EXEC, enc_i(12'(UART_ADDR), 5'd0, F3_LW, 5'd10, OPC_LOAD), '0, '0));
    rows.push_back(mkx(mk(OP_EXEC, enc_i(12'hFFF, 5'd0, F3_LW, 5'd11, OPC_LOAD), '0, '0),
                       11, 0, 1, 48, 0, 0, 0, STAT_RANGE));
    rows.push_back(mkx(mk(OP_EXEC, enc_s(12'hFFE, 5'd3, REG_SP, F3_SW), '0, '0),
                       0, 0, 0, 52, 0, 0, 0, STAT_RANGE));
    // Point the trap vector at x2, trap, and return.
    rows.push_back(mkx(mk(OP_EXEC, enc_i(CSR_MTVEC, REG_SP, F3_CSRRW, 5'd12, OPC_SYSTEM), '0,
                          '0), 12, 0, 1, 56, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_i(IMM_ECALL, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM), '0,
                          '0), 0, 0, 0, 32'(MEM), 1, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_EXEC, enc_i(IMM_MRET, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM), '0, '0),
                       0, 0, 0, 60, 0, 0, 0, STAT_OK));
    rows.push_back(mkx(mk(OP_FETCH, '0, '0, '0), 0, 0, 0, 60, 0, 0, 0, STAT_HALT));
    rows.push_back(mkx(mk(OP_EXEC, 32'hFFFF_FFFF, '0, '0), 0, 0, 0, 64, 0, 0, 0, STAT_UNSUP));
    // Jump home, load a small program word and fetch it.
    rows.push_back(mkx(mk(OP_EXEC, enc_i(12'd0, 5'd0, 3'd0, 5'd13, OPC_JALR), '0, '0),
                       13, 68, 1, 0, 0, 0, 0, STAT_OK));
    for (int k = 0; k < 4; k++)
      rows.push_back(mkx(mk(OP_POKE, '0, 12'(k), prog[8 * k +: 8]), 0, 0, 0, 0, 0, 0, 0,
                         STAT_OK));
    rows.push_back(mkx(mk(OP_FETCH, '0, '0, '0), 14, 5, 1, 4, 0, 0, 0, STAT_OK));

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

    sent = 0;
    while (sent < 1800) begin
      calm = (sent >= 1500);
      case ($urandom_range(0, 19))
        0, 1: begin
          // Jump somewhere, usually drop a word there, then fetch it.
          send_op(OP_EXEC, enc_i($urandom_range(0, 5) == 0 ? 12'($urandom)
                                                           : 12'(4 * $urandom_range(0, 511)),
                                 5'd0, 3'd0, pick_reg(), OPC_JALR), '0, '0);
          sent++;
          if ($urandom_range(0, 4) != 0) begin
            prog = random_word();
            for (int k = 0; k < 4; k++)
              send_op(OP_POKE, $urandom, 12'(shadow_pc + k), prog[8 * k +: 8]);
            sent += 4;
          end
          send_op(OP_FETCH, $urandom, 12'($urandom), 8'($urandom));
          sent++;
        end
        2: begin
          send_op(OP_POKE, $urandom, 12'($urandom), 8'($urandom));
          sent++;
        end
        3: begin
          send_op($urandom_range(0, 1) ? OP_NONE : OP_FETCH, $urandom, 12'($urandom),
                  8'($urandom));
          sent++;
        end
        default: begin
          send_op(OP_EXEC, random_word(), 12'($urandom), 8'($urandom));
          sent++;
        end
      endcase
    end

    @(negedge clk);
    req.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run including the clearing sweep.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
